FILE: hw/rtl/dadfa_pkg.sv
// Shared types and constants of the double-array DFA keyword matcher.
`default_nettype none

package dadfa_pkg;

    // Default table depths.
    localparam int MAX_STATES_DEF = 512;
    localparam int MAX_SLOTS_DEF  = 1024;

    // The byte alphabet is fixed by the scan byte width.
    localparam int ALPHABET = 256;
    localparam int CLS_AW   = $clog2(ALPHABET);

    // Field and entry widths.
    localparam int ACTION_W = 3;
    localparam int INDEX_W  = 10;
    localparam int VALUE_W  = 10;
    localparam int OWNER_W  = 10;
    localparam int BYTE_W   = 8;
    localparam int CLASS_W  = 7;
    localparam int BASE_W   = 10;
    localparam int STATE_W  = 9;
    localparam int ACC_W    = 8;
    localparam int SUM_W    = BASE_W + 1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CLASS  = 3'd0,
        ACT_BASE   = 3'd1,
        ACT_SLOT   = 3'd2,
        ACT_ACCEPT = 3'd3,
        ACT_SCAN   = 3'd4
    } action_t;

    // Table write request.
    typedef struct packed {
        logic                     cls_we;
        logic                     base_we;
        logic                     slot_we;
        logic                     acc_we;
        logic [INDEX_W-1:0]       index;
        logic [VALUE_W-1:0]       value;
        logic [OWNER_W-1:0]       owner;
    } tbl_wr_t;

    // Table read strobes.
    typedef struct packed {
        logic cls_base_en;
        logic slot_en;
        logic acc_en;
    } tbl_rd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dadfa_tables.sv
// Class map, base, next/owner and accept code memories with registered reads.
`default_nettype none

module dadfa_tables #(
    parameter int MAX_STATES = dadfa_pkg::MAX_STATES_DEF,
    parameter int MAX_SLOTS  = dadfa_pkg::MAX_SLOTS_DEF
) (
    input  wire logic                          aclk,
    input  wire dadfa_pkg::tbl_wr_t            wr,
    input  wire dadfa_pkg::tbl_rd_t            rd,
    input  wire logic [dadfa_pkg::CLS_AW-1:0]  cls_addr,
    input  wire logic [$clog2(MAX_STATES)-1:0] base_addr,
    input  wire logic [$clog2(MAX_SLOTS)-1:0]  slot_addr,
    input  wire logic [$clog2(MAX_STATES)-1:0] acc_addr,
    output logic [dadfa_pkg::CLASS_W-1:0]      cls_q,
    output logic [dadfa_pkg::BASE_W-1:0]       base_q,
    output logic [dadfa_pkg::STATE_W-1:0]      next_q,
    output logic [dadfa_pkg::OWNER_W-1:0]      owner_q,
    output logic [dadfa_pkg::ACC_W-1:0]        acc_q
);

    localparam int SIW = $clog2(MAX_STATES);
    localparam int SLW = $clog2(MAX_SLOTS);

    logic [dadfa_pkg::CLASS_W-1:0] class_mem  [dadfa_pkg::ALPHABET];
    logic [dadfa_pkg::BASE_W-1:0]  base_mem   [MAX_STATES];
    logic [dadfa_pkg::STATE_W-1:0] next_mem   [MAX_SLOTS];
    logic [dadfa_pkg::OWNER_W-1:0] owner_mem  [MAX_SLOTS];
    logic [dadfa_pkg::ACC_W-1:0]   accept_mem [MAX_STATES];

    always_ff @(posedge aclk) begin
        if (wr.cls_we) begin
            class_mem[wr.index[dadfa_pkg::CLS_AW-1:0]] <= wr.value[dadfa_pkg::CLASS_W-1:0];
        end
        if (rd.cls_base_en) begin
            cls_q <= class_mem[cls_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.base_we) begin
            base_mem[SIW'(wr.index)] <= wr.value[dadfa_pkg::BASE_W-1:0];
        end
        if (rd.cls_base_en) begin
            base_q <= base_mem[base_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.slot_we) begin
            next_mem[SLW'(wr.index)]  <= wr.value[dadfa_pkg::STATE_W-1:0];
            owner_mem[SLW'(wr.index)] <= wr.owner;
        end
        if (rd.slot_en) begin
            next_q  <= next_mem[slot_addr];
            owner_q <= owner_mem[slot_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.acc_we) begin
            accept_mem[SIW'(wr.index)] <= wr.value[dadfa_pkg::ACC_W-1:0];
        end
        if (rd.acc_en) begin
            acc_q <= accept_mem[acc_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/dadfa_walk.sv
// Transition pipeline: slot address, owner check, state update and result register.
`default_nettype none

module dadfa_walk #(
    parameter int MAX_STATES = dadfa_pkg::MAX_STATES_DEF,
    parameter int MAX_SLOTS  = dadfa_pkg::MAX_SLOTS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          scan_go,
    input  wire logic                          scan_last,
    input  wire logic [dadfa_pkg::CLASS_W-1:0] cls_q,
    input  wire logic [dadfa_pkg::BASE_W-1:0]  base_q,
    input  wire logic [dadfa_pkg::STATE_W-1:0] next_q,
    input  wire logic [dadfa_pkg::OWNER_W-1:0] owner_q,
    input  wire logic [dadfa_pkg::ACC_W-1:0]   acc_q,
    output dadfa_pkg::tbl_rd_t                 rd,
    output logic [$clog2(MAX_STATES)-1:0]      base_addr,
    output logic [$clog2(MAX_SLOTS)-1:0]       slot_addr,
    output logic [$clog2(MAX_STATES)-1:0]      acc_addr,
    output logic                               pipe_free,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_matched,
    output logic [dadfa_pkg::ACC_W-1:0]        m_accept_code
);

    localparam int SIW = $clog2(MAX_STATES);
    localparam int SLW = $clog2(MAX_SLOTS);

    logic                          a_vld_reg, a_vld_next;
    logic                          a_last_reg, a_last_next;
    logic                          b_vld_reg, b_vld_next;
    logic                          b_last_reg, b_last_next;
    logic                          b_inrange_reg, b_inrange_next;
    logic [dadfa_pkg::STATE_W-1:0] state_reg, state_next;
    logic                          rej_reg, rej_next;
    logic                          out_vld_reg, out_vld_next;
    logic                          out_match_reg, out_match_next;

    logic [dadfa_pkg::SUM_W-1:0]   slot_sum;
    logic                          a_inrange;
    logic                          out_free;
    logic                          commit;
    logic                          hit;
    logic                          walk_rej;
    logic [dadfa_pkg::STATE_W-1:0] walk_state;
    logic                          word_ok;

    always_comb begin
        slot_sum   = dadfa_pkg::SUM_W'(base_q) + dadfa_pkg::SUM_W'(cls_q);
        a_inrange  = (32'(state_reg) < 32'(MAX_STATES)) && (32'(slot_sum) < 32'(MAX_SLOTS));
        out_free   = !out_vld_reg || m_ready;
        commit     = b_vld_reg && (!b_last_reg || out_free);
        hit        = b_inrange_reg && (owner_q == {1'b0, state_reg});
        walk_rej   = rej_reg || !hit;
        walk_state = walk_rej ? state_reg : next_q;
        word_ok    = !walk_rej && (32'(walk_state) < 32'(MAX_STATES));
        pipe_free  = !a_vld_reg && (!b_vld_reg || commit);

        a_vld_next     = scan_go;
        a_last_next    = scan_go ? scan_last : a_last_reg;
        b_vld_next     = a_vld_reg || (b_vld_reg && !commit);
        b_last_next    = a_vld_reg ? a_last_reg : b_last_reg;
        b_inrange_next = a_vld_reg ? a_inrange : b_inrange_reg;

        state_next = state_reg;
        rej_next   = rej_reg;
        if (commit) begin
            if (b_last_reg) begin
                state_next = '0;
                rej_next   = 1'b0;
            end else begin
                state_next = walk_state;
                rej_next   = walk_rej;
            end
        end

        out_vld_next   = out_vld_reg && !m_ready;
        out_match_next = out_match_reg;
        if (commit && b_last_reg) begin
            out_vld_next   = 1'b1;
            out_match_next = word_ok;
        end

        rd.cls_base_en = scan_go;
        rd.slot_en     = a_vld_reg;
        rd.acc_en      = commit && b_last_reg;
        // The next byte's base lookup already uses the state this edge commits.
        base_addr      = SIW'(state_next);
        slot_addr      = SLW'(slot_sum);
        acc_addr       = SIW'(walk_state);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg     <= 1'b0;
            b_vld_reg     <= 1'b0;
            state_reg     <= '0;
            rej_reg       <= 1'b0;
            out_vld_reg   <= 1'b0;
        end else begin
            a_vld_reg     <= a_vld_next;
            b_vld_reg     <= b_vld_next;
            state_reg     <= state_next;
            rej_reg       <= rej_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_last_reg    <= a_last_next;
        b_last_reg    <= b_last_next;
        b_inrange_reg <= b_inrange_next;
        out_match_reg <= out_match_next;
    end

    assign m_valid       = out_vld_reg;
    assign m_matched     = out_match_reg;
    assign m_accept_code = out_match_reg ? acc_q : '0;

endmodule

`default_nettype wire

FILE: hw/rtl/double_array_dfa_keyword_matcher.sv
// Result path: a last scan byte passes the class/base read and slot read, then loads the
// result register once any held result is taken. Loads are taken every cycle while no scan
// byte is in its lookups; a scan byte waits for the prior byte's base read, slot read, state.
// Load requests write their table at the accepting edge; no tables are cleared.
// Reset: synchronous, active low; clears the walk pipeline, state, sticky reject and result.
`default_nettype none

module double_array_dfa_keyword_matcher #(
    parameter int MAX_STATES = dadfa_pkg::MAX_STATES_DEF,
    parameter int MAX_SLOTS  = dadfa_pkg::MAX_SLOTS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [dadfa_pkg::ACTION_W-1:0] s_action,
    input  wire logic [dadfa_pkg::INDEX_W-1:0]  s_table_index,
    input  wire logic [dadfa_pkg::VALUE_W-1:0]  s_load_value,
    input  wire logic signed [dadfa_pkg::OWNER_W-1:0] s_slot_owner,
    input  wire logic [dadfa_pkg::BYTE_W-1:0]   s_scan_byte,
    input  wire logic                           s_last_byte,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic                                m_matched,
    output logic [dadfa_pkg::ACC_W-1:0]         m_accept_code
);

    localparam int SIW = $clog2(MAX_STATES);
    localparam int SLW = $clog2(MAX_SLOTS);

    logic                          req_take;
    logic                          scan_go;
    logic                          pipe_free;
    dadfa_pkg::tbl_wr_t            wr;
    dadfa_pkg::tbl_rd_t            rd;
    logic [SIW-1:0]                base_addr;
    logic [SLW-1:0]                slot_addr;
    logic [SIW-1:0]                acc_addr;
    logic [dadfa_pkg::CLASS_W-1:0] cls_q;
    logic [dadfa_pkg::BASE_W-1:0]  base_q;
    logic [dadfa_pkg::STATE_W-1:0] next_q;
    logic [dadfa_pkg::OWNER_W-1:0] owner_q;
    logic [dadfa_pkg::ACC_W-1:0]   acc_q;

    // A new request is taken whenever no scan byte is still between its lookups.
    // This also keeps a load from overtaking the table reads of an earlier byte.
    assign s_ready  = pipe_free;
    assign req_take = s_valid && s_ready;

    // Decode the request into table writes or a scan start. Loads with an index past
    // the table depth, and unknown actions, are dropped.
    always_comb begin
        wr.cls_we  = 1'b0;
        wr.base_we = 1'b0;
        wr.slot_we = 1'b0;
        wr.acc_we  = 1'b0;
        wr.index   = s_table_index;
        wr.value   = s_load_value;
        wr.owner   = s_slot_owner;
        scan_go    = 1'b0;
        case (dadfa_pkg::action_t'(s_action))
            dadfa_pkg::ACT_CLASS: begin
                wr.cls_we = req_take && (32'(s_table_index) < 32'(dadfa_pkg::ALPHABET));
            end
            dadfa_pkg::ACT_BASE: begin
                wr.base_we = req_take && (32'(s_table_index) < 32'(MAX_STATES));
            end
            dadfa_pkg::ACT_SLOT: begin
                wr.slot_we = req_take && (32'(s_table_index) < 32'(MAX_SLOTS));
            end
            dadfa_pkg::ACT_ACCEPT: begin
                wr.acc_we = req_take && (32'(s_table_index) < 32'(MAX_STATES));
            end
            dadfa_pkg::ACT_SCAN: begin
                scan_go = req_take;
            end
            default: begin
                scan_go = 1'b0;
            end
        endcase
    end

    // All tables live here; every read is registered.
    dadfa_tables #(
        .MAX_STATES (MAX_STATES),
        .MAX_SLOTS  (MAX_SLOTS)
    ) u_tables (
        .aclk      (aclk),
        .wr        (wr),
        .rd        (rd),
        .cls_addr  (s_scan_byte),
        .base_addr (base_addr),
        .slot_addr (slot_addr),
        .acc_addr  (acc_addr),
        .cls_q     (cls_q),
        .base_q    (base_q),
        .next_q    (next_q),
        .owner_q   (owner_q),
        .acc_q     (acc_q)
    );

    // The walk forms the slot, checks its owner, moves the state and holds the result.
    dadfa_walk #(
        .MAX_STATES (MAX_STATES),
        .MAX_SLOTS  (MAX_SLOTS)
    ) u_walk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .scan_go       (scan_go),
        .scan_last     (s_last_byte),
        .cls_q         (cls_q),
        .base_q        (base_q),
        .next_q        (next_q),
        .owner_q       (owner_q),
        .acc_q         (acc_q),
        .rd            (rd),
        .base_addr     (base_addr),
        .slot_addr     (slot_addr),
        .acc_addr      (acc_addr),
        .pipe_free     (pipe_free),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_matched     (m_matched),
        .m_accept_code (m_accept_code)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/dadfa_checker.sv
// Port-level assertions for the keyword matcher and their bind to the top level.
`default_nettype none

module dadfa_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic [2:0] s_action,
    input wire logic       s_last_byte,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_matched,
    input wire logic [7:0] m_accept_code
);

    logic scan_take;
    logic last_take;

    assign scan_take = s_valid && s_ready && (s_action == dadfa_pkg::ACT_SCAN);
    assign last_take = scan_take && s_last_byte;

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_matched) && $stable(m_accept_code))
        else $error("result changed while stalled");

    a_reject_code_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_matched |-> m_accept_code == 8'd0)
        else $error("rejected word carries an accept code");

    a_scan_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_take |=> !s_ready)
        else $error("request taken while a scan byte is in its lookups");

    // The result register is loaded once the last byte has passed its class/base read and
    // its slot read, and only then can it be handed over.
    a_result_timing: assert property (@(posedge aclk) disable iff (!aresetn)
        last_take && !m_valid |-> ##3 m_valid)
        else $error("result missing three edges after the last byte");

    a_no_stray_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(last_take, 3))
        else $error("result without a last scan byte");

endmodule

bind double_array_dfa_keyword_matcher dadfa_checker u_dadfa_checker (.*);

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the double-array DFA keyword matcher.
`timescale 1ns / 1ps

module testbench;
    import dadfa_pkg::*;

    localparam int MAX_STATES    = MAX_STATES_DEF;
    localparam int MAX_SLOTS     = MAX_SLOTS_DEF;
    // Words are mostly walked through a small group of states whose
    // transitions the random part keeps adding, so the walks go deep.
    localparam int POOL_STATES   = 16;
    localparam int RANDOM_ITEMS  = 600;
    localparam int IDLE_MAX      = 11;
    localparam int DRAIN_CYCLES  = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_MAX    = 10;
    localparam int DIRECTED_ROWS = 25;

    // Action codes above the scan code are reserved and must be ignored.
    localparam logic [ACTION_W-1:0] ACT_RSVD_LO = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_RSVD_HI = 3'd7;
    // An all-ones owner marks an empty slot; it never equals a state.
    localparam logic signed [OWNER_W-1:0] OWNER_EMPTY = '1;

    // One request on the input channel, field by field.
    typedef struct packed {
        logic [ACTION_W-1:0]       act;
        logic [INDEX_W-1:0]        index;
        logic [VALUE_W-1:0]        value;
        logic signed [OWNER_W-1:0] owner;
        logic [BYTE_W-1:0]         chr;
        logic                      last;
    } request_t;

    // The verdict reported when a word ends.
    typedef struct packed {
        logic             matched;
        logic [ACC_W-1:0] code;
    } word_result_t;

    // A row of the directed table; the verdict is typed in where it is obvious.
    typedef struct packed {
        request_t     req;
        logic         has_verdict;
        word_result_t verdict;
    } directed_row_t;

    // The directed table builds a two-state recognizer by hand: byte 0x00 maps to
    // class 3, state 0 steps to state 1 through slot 3, and state 1 later loops
    // on itself through slot 1023. Around it, it hits the empty owner, the sticky
    // reject, a slot beyond the table, reserved actions, loads in the middle of a
    // word and loads whose index lies past the end of their table.
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{'{ACT_CLASS,  10'd0,    10'd3,    10'sd0,      8'h00, 1'b0}, 1'b0, '{1'b0, 8'h00}},
        '{'{ACT_CLASS,  10'd255,  10'd1023, 10'sd0,      8'hFF, 1'b1}, 1'b0, '{1'b0, 8'h00}},
        '{'{ACT_BASE,   10'd0,    10'd0,    10'sd0,      8'h00, 1'b0}, 1'b0, '{1'b0, 8'h00}},
        '{'{ACT_SLOT,   10'd3,    10'd1,    10'sd0,      8'h00, 1'b0}, 1'b0, '{1'b0, 8'h00}},
        '{'{ACT_SLOT,   10'd127,  10'd0,    OWNER_EMPTY, 8'h00, 1'b0}, 1'b0, '{1'b0, 8'h00}},
        '{'{ACT_ACCEPT, 10'd1,    10'h2AB,  10'sd0,      8'h00, 1'b0}, 1'b0, '{1'b0, 8'h00}},
        '{'{ACT_SCAN,   10'd0,    10'd0,    10'sd0,      8'h00, 1'b1}, 1'b1, '{1'b1, 8'hAB}},
        '{'{ACT_SCAN,   10'd0,    10'd0,    10'sd0,      8'hFF, 1'b1}, 1'b1, '{1'b0, 8'h00}},
        '{'{ACT_SCAN,   10'h3FF,  10'h3FF,  OWNER_EMPTY, 8'hFF, 1'b0}, 1'b0, '{1'b0, 8'h00}},
        '{'{ACT_SCAN,   10'd0,    10'd0,    10'sd0,      8'h00, 1'b1}, 1'b1, '{1'b0, 8'h00}},
        '{'{ACT_BASE,   10'd1,    10'd1023, 10'sd0,      8'h00, 1'b0}, 1'b0, '{1'b0, 8'h00}},
        '{'{ACT_SCAN,   10'd0,    10'd0,    10'sd0,      8'h00, 1'b0}, 1'b0, '{1'b0, 8'h00}},
        '{'{ACT_SCAN,   10'd0,    10'd0,    10'sd0,      8'h00, 1'b1}, 1'b1, '{1'b0, 8'h00}},
        '{'{ACT_SCAN,   10'd0,    10'd0,    10'sd0,      8'h00, 1'b0}, 1'b0, '{1'b0, 8'h00}},
        '{'{ACT_RSVD_LO, 10'd3,   10'd5,    10'sd2,      8'h00, 1'b1}, 1'b0, '{1'b0, 8'h00}},
        '{'{ACT_ACCEPT, 10'd1,    10'h055,  10'sd0,      8'h00, 1'b0}, 1'b0, '{1'b0, 8'h00}},
        '{'{ACT_BASE,   10'd1,    10'd1020, 10'sd0,      8'h00, 1'b0}, 1'b0, '{1'b0, 8'h00}},
        '{'{ACT_SLOT,   10'd1023, 10'd1,    10'sd1,      8'h00, 1'b0}, 1'b0, '{1'b0, 8'h00}},
        '{'{ACT_SCAN,   10'd0,    10'd0,    10'sd0,      8'h00, 1'b1}, 1'b1, '{1'b1, 8'h55}},
        '{'{ACT_RSVD_HI, 10'h3FF, 10'h3FF,  OWNER_EMPTY, 8'hFF, 1'b1}, 1'b0, '{1'b0, 8'h00}},
        '{'{ACT_CLASS,  10'd256,  10'd50,   10'sd0,      8'h00, 1'b0}, 1'b0, '{1'b0, 8'h00}},
        '{'{ACT_BASE,   10'd512,  10'd900,  10'sd0,      8'h00, 1'b0}, 1'b0, '{1'b0, 8'h00}},
        '{'{ACT_ACCEPT, 10'd513,  10'd7,    10'sd0,      8'h00, 1'b0}, 1'b0, '{1'b0, 8'h00}},
        '{'{ACT_SCAN,   10'd0,    10'd0,    10'sd0,      8'h00, 1'b0}, 1'b0, '{1'b0, 8'h00}},
        '{'{ACT_SCAN,   10'd0,    10'd0,    10'sd0,      8'h00, 1'b1}, 1'b1, '{1'b1, 8'h55}}
    };

    logic                      aclk;
    logic                      aresetn       = 1'b0;
    logic                      s_valid       = 1'b0;
    logic                      s_ready;
    logic [ACTION_W-1:0]       s_action      = '0;
    logic [INDEX_W-1:0]        s_table_index = '0;
    logic [VALUE_W-1:0]        s_load_value  = '0;
    logic signed [OWNER_W-1:0] s_slot_owner  = '0;
    logic [BYTE_W-1:0]         s_scan_byte   = '0;
    logic                      s_last_byte   = 1'b0;
    logic                      m_valid;
    logic                      m_ready       = 1'b0;
    logic                      m_matched;
    logic [ACC_W-1:0]          m_accept_code;

    // Shadow copy of the tables and of the walk, kept in step with accepted requests.
    bit [CLASS_W-1:0] cls_of   [ALPHABET];
    bit [BASE_W-1:0]  base_of  [MAX_STATES];
    bit [STATE_W-1:0] next_of  [MAX_SLOTS];
    bit [OWNER_W-1:0] owner_of [MAX_SLOTS];
    bit [ACC_W-1:0]   code_of  [MAX_STATES];
    bit [STATE_W-1:0] walk_state;
    bit               walk_rejected;

    // Verdicts still owed by the block, oldest first.
    word_result_t verdict_q [$];

    int  error_count   = 0;
    int  reported      = 0;
    int  results_seen  = 0;
    int  matches_seen  = 0;
    int  request_count = 0;
    int  setup_count   = 0;
    int  cycle_count   = 0;
    bit  counting      = 1'b0;
    int  src_idle_max  = IDLE_MAX;
    int  sink_idle_max = IDLE_MAX;

    double_array_dfa_keyword_matcher u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_table_index (s_table_index),
        .s_load_value  (s_load_value),
        .s_slot_owner  (s_slot_owner),
        .s_scan_byte   (s_scan_byte),
        .s_last_byte   (s_last_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_matched     (m_matched),
        .m_accept_code (m_accept_code)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // A hung handshake ends the run here.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles with %0d verdicts outstanding",
                 cycle_count, verdict_q.size());
        $display("testbench: errors");
        $finish;
    end

    // Idle cycles before the next request or result; a maximum of zero means a
    // back-to-back stretch.
    function automatic int draw_idle(input int max_idle);
        return (max_idle == 0) ? 0 : int'($urandom_range(0, max_idle));
    endfunction

    // Applies one accepted request to the shadow tables and the walk. Returns 1
    // with the verdict when the request ends a word.
    function automatic bit predict_word(input request_t r, output word_result_t res);
        int slot;
        res = '0;
        case (r.act)
            ACT_CLASS: begin
                if (r.index < ALPHABET) cls_of[r.index] = r.value[CLASS_W-1:0];
                return 1'b0;
            end
            ACT_BASE: begin
                if (r.index < MAX_STATES) base_of[r.index] = r.value[BASE_W-1:0];
                return 1'b0;
            end
            ACT_SLOT: begin
                if (r.index < MAX_SLOTS) begin
                    next_of[r.index]  = r.value[STATE_W-1:0];
                    owner_of[r.index] = r.owner;
                end
                return 1'b0;
            end
            ACT_ACCEPT: begin
                if (r.index < MAX_STATES) code_of[r.index] = r.value[ACC_W-1:0];
                return 1'b0;
            end
            ACT_SCAN: begin
                // Once a word is rejected its remaining bytes do no lookups. The
                // state is nine bits wide, so it never lies past the state table.
                if (!walk_rejected) begin
                    slot = int'(base_of[walk_state]) + int'(cls_of[r.chr]);
                    if (slot >= MAX_SLOTS || owner_of[slot] != {1'b0, walk_state})
                        walk_rejected = 1'b1;
                    else
                        walk_state = next_of[slot];
                end
                if (!r.last) return 1'b0;
                res.matched   = !walk_rejected;
                res.code      = walk_rejected ? '0 : code_of[walk_state];
                walk_state    = '0;
                walk_rejected = 1'b0;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Presents one request, holds it until the block takes it, then updates the
    // shadow state. A typed-in verdict, where given, is queued instead of the
    // predicted one. Valid is only lowered when an idle gap follows, so it is
    // never dropped and raised in the same step.
    task automatic send_request(input request_t r, input bit typed_valid,
                                input word_result_t typed);
        int           gap;
        word_result_t predicted;
        gap = draw_idle(src_idle_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_action      <= r.act;
        s_table_index <= r.index;
        s_load_value  <= r.value;
        s_slot_owner  <= r.owner;
        s_scan_byte   <= r.chr;
        s_last_byte   <= r.last;
        do @(posedge aclk); while (!s_ready);
        if (predict_word(r, predicted))
            verdict_q.push_back(typed_valid ? typed : predicted);
        // Reserved actions are ignored by the block and do not count as traffic.
        if (counting && r.act <= ACT_SCAN) request_count++;
    endtask

    // A load with every field random, reserved actions excluded.
    function automatic request_t make_noise_load();
        request_t r;
        r.act   = ACTION_W'($urandom_range(ACT_CLASS, ACT_ACCEPT));
        r.index = INDEX_W'($urandom);
        r.value = VALUE_W'($urandom);
        r.owner = ($urandom_range(0, 3) == 0) ? OWNER_EMPTY
                                              : OWNER_W'($urandom_range(0, MAX_STATES - 1));
        r.chr   = BYTE_W'($urandom);
        r.last  = 1'($urandom);
        return r;
    endfunction

    // Result side: a random stall before each result, with stretches of none.
    initial begin
        int stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            stall = draw_idle(sink_idle_max);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Every verdict the block hands over is compared with the oldest one owed.
    always @(posedge aclk) begin
        word_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (verdict_q.size() == 0) begin
                error_count++;
                if (reported < REPORT_MAX) begin
                    reported++;
                    $display("unexpected verdict at cycle %0d: matched=%0b code=0x%02h",
                             cycle_count, m_matched, m_accept_code);
                end
            end else begin
                want = verdict_q.pop_front();
                if (want.matched) matches_seen++;
                if (m_matched !== want.matched || m_accept_code !== want.code) begin
                    error_count++;
                    if (reported < REPORT_MAX) begin
                        reported++;
                        $display("verdict mismatch at cycle %0d: expected matched=%0b code=0x%02h, got matched=%0b code=0x%02h",
                                 cycle_count, want.matched, want.code, m_matched,
                                 m_accept_code);
                    end
                end
            end
        end
    end

    initial begin
        request_t          r;
        int                kind;
        int                len;
        int                slot;
        int                cls;
        int                st;
        logic [BYTE_W-1:0] valid_bytes [$];

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Hand-built recognizer first, while every table read is still under control.
        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_request(DIRECTED[i].req, DIRECTED[i].has_verdict, DIRECTED[i].verdict);

        // Fill every table entry back to back, so no later lookup can land on an
        // entry that was never written. Some classes lie between 64 and 127 and can
        // push slots past the slot table. Pool state bases keep the slots of classes
        // below 64 inside it, and about a third of all slots get an owner.
        src_idle_max  = 0;
        sink_idle_max = 0;
        for (int b = 0; b < ALPHABET; b++) begin
            r       = make_noise_load();
            r.act   = ACT_CLASS;
            r.index = INDEX_W'(b);
            cls     = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 127)
                                                  : $urandom_range(0, 63);
            r.value = VALUE_W'(($urandom_range(0, 7) << CLASS_W) | cls);
            send_request(r, 1'b0, '0);
            setup_count++;
        end
        for (int s = 0; s < MAX_STATES; s++) begin
            r       = make_noise_load();
            r.act   = ACT_BASE;
            r.index = INDEX_W'(s);
            r.value = VALUE_W'((s < POOL_STATES) ? $urandom_range(0, 959)
                                                 : $urandom_range(0, 1023));
            send_request(r, 1'b0, '0);
            r.act   = ACT_ACCEPT;
            r.value = VALUE_W'($urandom);
            send_request(r, 1'b0, '0);
            setup_count += 2;
        end
        for (int k = 0; k < MAX_SLOTS; k++) begin
            r       = make_noise_load();
            r.act   = ACT_SLOT;
            r.index = INDEX_W'(k);
            r.value = VALUE_W'(($urandom_range(0, 1) << STATE_W)
                               | $urandom_range(0, POOL_STATES - 1));
            r.owner = ($urandom_range(0, 9) < 7) ? OWNER_EMPTY
                                                 : OWNER_W'($urandom_range(0, POOL_STATES - 1));
            send_request(r, 1'b0, '0);
            setup_count++;
        end

        // Random traffic in episodes. Most episodes are words that follow real
        // transitions; the rest grow the recognizer, scribble on tables or send
        // reserved actions. Each episode redraws whether either side idles.
        counting = 1'b1;
        while (request_count < RANDOM_ITEMS) begin
            src_idle_max  = ($urandom_range(0, 5) == 0) ? 0 : IDLE_MAX;
            sink_idle_max = ($urandom_range(0, 5) == 0) ? 0 : IDLE_MAX;
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
                // A word: most bytes take a valid transition where one exists,
                // the rest are random and usually reject the word.
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12)
                                                  : $urandom_range(1, 6);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 99) < 8)
                        send_request(make_noise_load(), 1'b0, '0);
                    r      = make_noise_load();
                    r.act  = ACT_SCAN;
                    r.last = (k == len - 1);
                    if (!walk_rejected && $urandom_range(0, 99) < 85) begin
                        valid_bytes.delete();
                        for (int b = 0; b < ALPHABET; b++) begin
                            slot = int'(base_of[walk_state]) + int'(cls_of[b]);
                            if (slot < MAX_SLOTS && owner_of[slot] == {1'b0, walk_state})
                                valid_bytes.push_back(BYTE_W'(b));
                        end
                        if (valid_bytes.size() > 0)
                            r.chr = valid_bytes[$urandom_range(0, valid_bytes.size() - 1)];
                    end
                    send_request(r, 1'b0, '0);
                end
            end else if (kind < 85) begin
                // Grow the recognizer: give pool states new transitions, mostly
                // into the pool, and now and then a new accept code.
                repeat ($urandom_range(1, 4)) begin
                    st      = $urandom_range(0, POOL_STATES - 1);
                    r       = make_noise_load();
                    r.chr   = BYTE_W'($urandom);
                    slot    = int'(base_of[st]) + int'(cls_of[r.chr]);
                    if (slot < MAX_SLOTS) begin
                        r.act   = ACT_SLOT;
                        r.index = INDEX_W'(slot);
                        r.owner = OWNER_W'(st);
                        r.value = ($urandom_range(0, 9) == 0)
                                  ? VALUE_W'($urandom)
                                  : VALUE_W'(($urandom_range(0, 1) << STATE_W)
                                             | $urandom_range(0, POOL_STATES - 1));
                    end else begin
                        // The slot would lie past the table: draw a new base below 960.
                        r.act   = ACT_BASE;
                        r.index = INDEX_W'(st);
                        r.value = VALUE_W'($urandom_range(0, 959));
                    end
                    send_request(r, 1'b0, '0);
                end
                if ($urandom_range(0, 4) == 0) begin
                    r       = make_noise_load();
                    r.act   = ACT_ACCEPT;
                    r.index = INDEX_W'($urandom_range(0, POOL_STATES - 1));
                    send_request(r, 1'b0, '0);
                end
            end else if (kind < 95) begin
                send_request(make_noise_load(), 1'b0, '0);
            end else begin
                r     = make_noise_load();
                r.act = ACTION_W'($urandom_range(ACT_RSVD_LO, ACT_RSVD_HI));
                send_request(r, 1'b0, '0);
            end
        end

        // Wait for every owed verdict, then give the block time to show anything extra.
        s_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d directed requests, %0d table fill loads and %0d random requests.",
                 DIRECTED_ROWS, setup_count, request_count);
        $display("Checked %0d word verdicts, %0d of them keyword matches, in %0d cycles.",
                 results_seen, matches_seen, cycle_count);
        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
